### src/qjt_pkg.sv
// ----------------------------------------------------------------------------
// qjt_pkg
// Shared constants, types and tables of the quintic joint trajectory unit.
// ----------------------------------------------------------------------------
package qjt_pkg;

   // Joint count and field widths
   localparam int JOINT_COUNT = 7;
   localparam int JOINT_IDX_W = 3;
   localparam int ANGLE_W     = 32;
   localparam int DELTA_W     = 33;
   localparam int PERIOD_W    = 16;
   localparam int SF_W        = 17;
   localparam int TIME_W      = 32;
   localparam int FRAC_W      = 30;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_FACTOR = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOAL_FIRST   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOAL_LAST    = 4'd7;

   // Shared multiplier: 64 x 32 bits in two 32 x 32 passes
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = 96;

   // Shared divide / square root unit
   localparam int DIV_REM_W     = 36;
   localparam int DIV_DQ_W      = 96;
   localparam int DIV_DIVISOR_W = 34;
   localparam int DIV_CNT_W     = 7;
   localparam int ROOT_W        = 32;

   // Speed factor limits (Q1.16)
   localparam logic [SF_W-1:0] SF_ONE = 17'd65536;
   localparam logic [SF_W-1:0] SF_MIN = 17'd1;

   // Scale constants of the time bounds
   localparam logic [MUL_B_W-1:0] VEL_SCALE = 32'd150000000;
   localparam logic [MUL_B_W-1:0] ACC_K     = 32'd378372;
   localparam logic [MUL_B_W-1:0] ACC_SCALE = 32'd781250000;

   // Iteration counts: significant dividend bits of each division
   localparam logic [DIV_CNT_W-1:0] VEL_DIV_BITS = 7'd60;
   localparam logic [DIV_CNT_W-1:0] ACC_DIV_BITS = 7'd81;
   localparam logic [DIV_CNT_W-1:0] SQRT_STEPS   = 7'd32;
   localparam logic [DIV_CNT_W-1:0] TAU_BITS     = 7'd30;

   // Velocity limit per joint in tenths of rad/s
   function automatic logic [4:0] vmax_tenths(input logic [JOINT_IDX_W-1:0] joint);
      logic [4:0] v;
      v = (joint < 3'd4) ? 5'd20 : 5'd25;
      return v;
   endfunction

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } qjt_mul_cmd_type;

   typedef struct packed {
      logic               done;
      logic [MUL_P_W-1:0] prod;
   } qjt_mul_rsp_type;

   typedef struct packed {
      logic                     start;
      logic                     sqrt_mode;
      logic [DIV_CNT_W-1:0]     count;
      logic [DIV_REM_W-1:0]     rem_init;
      logic [DIV_DIVISOR_W-1:0] divisor;
      logic [DIV_DQ_W-1:0]      dividend;
   } qjt_div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [DIV_DQ_W-1:0] quot;
      logic [ROOT_W-1:0]   root;
   } qjt_div_rsp_type;

endpackage

### src/qjt_req_if.sv
// ----------------------------------------------------------------------------
// qjt_req_if
// Tick request channel: period and current commanded joint angles.
// ----------------------------------------------------------------------------
interface qjt_req_if import qjt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] period_us;
   logic [ANGLE_W-1:0]  start_angle_0;
   logic [ANGLE_W-1:0]  start_angle_1;
   logic [ANGLE_W-1:0]  start_angle_2;
   logic [ANGLE_W-1:0]  start_angle_3;
   logic [ANGLE_W-1:0]  start_angle_4;
   logic [ANGLE_W-1:0]  start_angle_5;
   logic [ANGLE_W-1:0]  start_angle_6;

   modport source (output valid, period_us, start_angle_0, start_angle_1, start_angle_2,
                   start_angle_3, start_angle_4, start_angle_5, start_angle_6,
                   input ready);
   modport sink (input valid, period_us, start_angle_0, start_angle_1, start_angle_2,
                 start_angle_3, start_angle_4, start_angle_5, start_angle_6,
                 output ready);
endinterface

### src/qjt_rsp_if.sv
// ----------------------------------------------------------------------------
// qjt_rsp_if
// Setpoint response channel: joint setpoints and finished flag.
// ----------------------------------------------------------------------------
interface qjt_rsp_if import qjt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] setpoint_0;
   logic [ANGLE_W-1:0] setpoint_1;
   logic [ANGLE_W-1:0] setpoint_2;
   logic [ANGLE_W-1:0] setpoint_3;
   logic [ANGLE_W-1:0] setpoint_4;
   logic [ANGLE_W-1:0] setpoint_5;
   logic [ANGLE_W-1:0] setpoint_6;
   logic               finished;

   modport source (output valid, setpoint_0, setpoint_1, setpoint_2, setpoint_3,
                   setpoint_4, setpoint_5, setpoint_6, finished,
                   input ready);
   modport sink (input valid, setpoint_0, setpoint_1, setpoint_2, setpoint_3,
                 setpoint_4, setpoint_5, setpoint_6, finished,
                 output ready);
endinterface

### src/qjt_csr_if.sv
// ----------------------------------------------------------------------------
// qjt_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface qjt_csr_if import qjt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/qjt_mul.sv
// ----------------------------------------------------------------------------
// qjt_mul
// Shared 64 x 32 bit unsigned multiplier built from one 32 x 32 multiplier
// used twice; the result is held until the next command.
// ----------------------------------------------------------------------------
module qjt_mul import qjt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  qjt_mul_cmd_type cmd,
   output qjt_mul_rsp_type rsp
);

   typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_SUM} phase_type;

   phase_type          phase_ff, phase_in;
   logic               done_ff, done_in;
   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic [63:0]        lo_ff, lo_in;
   logic [63:0]        hi_ff, hi_in;
   logic [MUL_P_W-1:0] res_ff, res_in;
   logic [31:0]        mult_op;
   logic [63:0]        mult_p;

   // One 32 x 32 multiplier, low half of a first
   assign mult_op = (phase_ff == M_LO) ? a_ff[31:0] : a_ff[63:32];
   assign mult_p  = mult_op * b_ff;

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      a_in     = a_ff;
      b_in     = b_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      res_in   = res_ff;
      unique case (phase_ff)
         M_IDLE: begin
            if (cmd.start) begin
               a_in     = cmd.a;
               b_in     = cmd.b;
               phase_in = M_LO;
            end
         end
         M_LO: begin
            lo_in    = mult_p;
            phase_in = M_HI;
         end
         M_HI: begin
            hi_in    = mult_p;
            phase_in = M_SUM;
         end
         M_SUM: begin
            // combine partial products
            res_in   = {hi_ff, 32'b0} + {32'b0, lo_ff};
            done_in  = 1'b1;
            phase_in = M_IDLE;
         end
         default: phase_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      res_ff <= res_in;
      if (reset) begin
         phase_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = res_ff;

endmodule

### src/qjt_divsqrt.sv
// ----------------------------------------------------------------------------
// qjt_divsqrt
// Shared restoring divider and digit-by-digit square root, one quotient or
// root bit per cycle, sharing one compare and subtract.
// ----------------------------------------------------------------------------
module qjt_divsqrt import qjt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  qjt_div_cmd_type cmd,
   output qjt_div_rsp_type rsp
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     sqrt_ff, sqrt_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_REM_W-1:0]     rem_ff, rem_in;
   logic [DIV_DQ_W-1:0]      dq_ff, dq_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic [DIV_DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [DIV_REM_W-1:0]     trial_x;
   logic [DIV_REM_W-1:0]     trial_y;
   logic [DIV_REM_W-1:0]     trial_diff;
   logic                     trial_ge;

   // Shared trial subtract: divisor, or 4*root+1 for the square root
   always_comb begin
      if (sqrt_ff) begin
         trial_x = {rem_ff[DIV_REM_W-3:0], dq_ff[DIV_DQ_W-1 -: 2]};
         trial_y = {2'b0, root_ff, 2'b01};
      end else begin
         trial_x = {rem_ff[DIV_REM_W-2:0], dq_ff[DIV_DQ_W-1]};
         trial_y = {{(DIV_REM_W-DIV_DIVISOR_W){1'b0}}, divisor_ff};
      end
      trial_ge   = (trial_x >= trial_y);
      trial_diff = trial_x - trial_y;
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      sqrt_in    = sqrt_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      root_in    = root_ff;
      divisor_in = divisor_ff;
      if (busy_ff) begin
         // advance one bit
         rem_in  = trial_ge ? trial_diff : trial_x;
         root_in = {root_ff[ROOT_W-2:0], trial_ge};
         if (sqrt_ff) begin
            dq_in = {dq_ff[DIV_DQ_W-3:0], 2'b0};
         end else begin
            dq_in = {dq_ff[DIV_DQ_W-2:0], trial_ge};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in    = 1'b1;
         sqrt_in    = cmd.sqrt_mode;
         cnt_in     = cmd.count;
         rem_in     = cmd.rem_init;
         dq_in      = cmd.dividend;
         root_in    = '0;
         divisor_in = cmd.divisor;
      end
   end

   always_ff @(posedge clock) begin
      sqrt_ff    <= sqrt_in;
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      root_ff    <= root_in;
      divisor_ff <= divisor_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = dq_ff;
   assign rsp.root = root_ff;

endmodule

### src/quintic_joint_trajectory_unit.sv
// ----------------------------------------------------------------------------
// quintic_joint_trajectory_unit
// Quintic point-to-point setpoint generator for seven joints.
// ----------------------------------------------------------------------------
// Channels: req_ch carries one tick request (period in microseconds and the
// current commanded angles); rsp_ch returns one set of setpoints and the
// finished flag per request; csr_ch writes the speed factor (index 0) and
// the goal angles (index 1 to 7). Register writes are taken at any time and
// must only be issued while no request is in flight.
// A sequencer drives one shared 2-pass multiplier and one shared divide /
// square root unit (one bit a cycle). A plain tick advances time, runs the
// 30-bit normalized time division and the three polynomial products, then
// works out the product and sum of each joint and loads the output; a tick
// that ends the move goes from advancing time straight to loading the output.
// The first tick after reset or a register write also plans the move: per
// joint three products, a 60-bit and an 81-bit division and a 32-step root.
// A new request is taken only once the previous one has been worked through.
// req_ch.ready is high only while the sequencer is idle. A finished response
// sits in an output register; the next request is accepted and worked on
// while it waits, and results stall only if the receiver still holds the
// previous one. Reset clears the motion state and sets the speed factor
// to 1.
// ----------------------------------------------------------------------------
module quintic_joint_trajectory_unit import qjt_pkg::*; (
   input logic        clock,
   input logic        reset,
   qjt_req_if.sink    req_ch,
   qjt_rsp_if.source  rsp_ch,
   qjt_csr_if.sink    csr_ch
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DELTA, ST_VMUL, ST_VDIV, ST_KMUL, ST_AMUL, ST_ADIV, ST_SQRT,
      ST_ADVANCE, ST_TAU, ST_T2, ST_T3, ST_POLY, ST_JMUL, ST_JSUM, ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic                     started_ff, started_in;
   logic [SF_W-1:0]          sf_ff, sf_in;
   logic [ANGLE_W-1:0]       goal_ff   [JOINT_COUNT];
   logic [ANGLE_W-1:0]       goal_in   [JOINT_COUNT];
   logic [ANGLE_W-1:0]       start_ff  [JOINT_COUNT];
   logic [ANGLE_W-1:0]       start_in  [JOINT_COUNT];
   logic [DELTA_W-1:0]       delta_ff  [JOINT_COUNT];
   logic [DELTA_W-1:0]       delta_in  [JOINT_COUNT];
   logic [ANGLE_W-1:0]       setpt_ff  [JOINT_COUNT];
   logic [ANGLE_W-1:0]       setpt_in  [JOINT_COUNT];
   logic [ANGLE_W-1:0]       out_ff    [JOINT_COUNT];
   logic [ANGLE_W-1:0]       out_in    [JOINT_COUNT];
   logic [ANGLE_W-1:0]       req_angle [JOINT_COUNT];
   logic                     out_fin_ff, out_fin_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     fin_ff, fin_in;
   logic                     mul_start_ff, mul_start_in;
   logic                     div_start_ff, div_start_in;
   logic [JOINT_IDX_W-1:0]   jidx_ff, jidx_in;
   logic [PERIOD_W-1:0]      period_ff, period_in;
   logic [TIME_W-1:0]        motion_ff, motion_in;
   logic [TIME_W-1:0]        elapsed_ff, elapsed_in;
   logic [ANGLE_W-1:0]       mag_ff, mag_in;
   logic [TIME_W-1:0]        tv_ff, tv_in;
   logic [63:0]              rsat_ff, rsat_in;
   logic [FRAC_W-1:0]        tau_ff, tau_in;
   logic [FRAC_W-1:0]        t2_ff, t2_in;
   logic [FRAC_W-1:0]        t3_ff, t3_in;
   logic [MUL_B_W-1:0]       s_ff, s_in;
   logic [63:0]              prod_ff, prod_in;

   qjt_mul_cmd_type          mul_cmd;
   qjt_mul_rsp_type          mul_rsp;
   qjt_div_cmd_type          div_cmd;
   qjt_div_rsp_type          div_rsp;

   logic [SF_W-1:0]          sf_eff;
   logic [21:0]              vprod;
   logic [TIME_W-1:0]        vden;
   logic [35:0]              inner;
   logic [DELTA_W-1:0]       delta_sel;
   logic [ANGLE_W-1:0]       delta_mag;
   logic [JOINT_IDX_W-1:0]   csr_goal_idx;
   logic [DELTA_W-1:0]       new_delta;
   logic [TIME_W:0]          elapsed_sum;
   logic [TIME_W-1:0]        elapsed_new;
   logic [TIME_W-1:0]        bound;
   logic [64:0]              scaled_biased;
   logic [ANGLE_W-1:0]       scaled_q;
   logic [ANGLE_W-1:0]       scaled;

   qjt_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   qjt_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign req_angle[0] = req_ch.start_angle_0;
   assign req_angle[1] = req_ch.start_angle_1;
   assign req_angle[2] = req_ch.start_angle_2;
   assign req_angle[3] = req_ch.start_angle_3;
   assign req_angle[4] = req_ch.start_angle_4;
   assign req_angle[5] = req_ch.start_angle_5;
   assign req_angle[6] = req_ch.start_angle_6;

   // Clamp the speed factor into 2^-16..1.0
   always_comb begin
      if (sf_ff == '0) begin
         sf_eff = SF_MIN;
      end else if (sf_ff > SF_ONE) begin
         sf_eff = SF_ONE;
      end else begin
         sf_eff = sf_ff;
      end
   end

   // Velocity bound divisor: 2048 * vmax10 * sf
   assign vprod = {5'b0, sf_eff} * {17'b0, vmax_tenths(jidx_ff)};
   assign vden  = {vprod[20:0], 11'b0};

   // Inner polynomial term 10 - 15 tau + 6 tau^2 in Q30
   assign inner = (36'd10 << FRAC_W) + ({6'b0, t2_ff} * 36'd6) - ({6'b0, tau_ff} * 36'd15);

   // Magnitude of the selected joint delta
   assign delta_sel = delta_ff[jidx_ff];
   assign delta_mag = delta_sel[DELTA_W-1] ? ANGLE_W'(-delta_sel) : delta_sel[ANGLE_W-1:0];

   assign csr_goal_idx = JOINT_IDX_W'(csr_ch.index - CSR_GOAL_FIRST);
   assign new_delta    = {goal_ff[jidx_ff][ANGLE_W-1], goal_ff[jidx_ff]}
                       - {start_ff[jidx_ff][ANGLE_W-1], start_ff[jidx_ff]};

   // Saturating elapsed time
   assign elapsed_sum = {1'b0, elapsed_ff} + {{(TIME_W+1-PERIOD_W){1'b0}}, period_ff};
   assign elapsed_new = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];

   // Larger of the velocity bound and the acceleration bound
   assign bound = (tv_ff > div_rsp.root) ? tv_ff : div_rsp.root;

   // Floor of delta * s / 2^30, rounding toward minus infinity
   assign scaled_biased = {1'b0, prod_ff}
                        + (delta_sel[DELTA_W-1] ? 65'h3FFF_FFFF : 65'd0);
   assign scaled_q      = scaled_biased[FRAC_W +: ANGLE_W];
   assign scaled        = delta_sel[DELTA_W-1] ? -scaled_q : scaled_q;

   // Multiplier operands per step
   always_comb begin
      mul_cmd.start = mul_start_ff;
      mul_cmd.a     = '0;
      mul_cmd.b     = '0;
      unique case (state_ff)
         ST_VMUL: begin
            mul_cmd.a = {32'b0, mag_ff};
            mul_cmd.b = VEL_SCALE;
         end
         ST_KMUL: begin
            mul_cmd.a = {32'b0, mag_ff};
            mul_cmd.b = ACC_K;
         end
         ST_AMUL: begin
            mul_cmd.a = mul_rsp.prod[MUL_A_W-1:0];
            mul_cmd.b = ACC_SCALE;
         end
         ST_T2: begin
            mul_cmd.a = {34'b0, tau_ff};
            mul_cmd.b = {2'b0, tau_ff};
         end
         ST_T3: begin
            mul_cmd.a = {34'b0, t2_ff};
            mul_cmd.b = {2'b0, tau_ff};
         end
         ST_POLY: begin
            mul_cmd.a = {28'b0, inner};
            mul_cmd.b = {2'b0, t3_ff};
         end
         ST_JMUL: begin
            mul_cmd.a = {32'b0, delta_mag};
            mul_cmd.b = s_ff;
         end
         default: begin
            mul_cmd.a = '0;
            mul_cmd.b = '0;
         end
      endcase
   end

   // Divide / root operands per step, dividend aligned to the top
   always_comb begin
      div_cmd.start     = div_start_ff;
      div_cmd.sqrt_mode = 1'b0;
      div_cmd.count     = TAU_BITS;
      div_cmd.rem_init  = '0;
      div_cmd.divisor   = '0;
      div_cmd.dividend  = '0;
      unique case (state_ff)
         ST_VDIV: begin
            div_cmd.count    = VEL_DIV_BITS;
            div_cmd.divisor  = {2'b0, vden};
            div_cmd.dividend = {mul_rsp.prod[59:0], 36'b0};
         end
         ST_ADIV: begin
            div_cmd.count    = ACC_DIV_BITS;
            div_cmd.divisor  = {1'b0, sf_eff, 16'b0};
            div_cmd.dividend = {mul_rsp.prod[80:0], 15'b0};
         end
         ST_SQRT: begin
            div_cmd.sqrt_mode = 1'b1;
            div_cmd.count     = SQRT_STEPS;
            div_cmd.dividend  = {rsat_ff, 32'b0};
         end
         ST_TAU: begin
            div_cmd.count    = TAU_BITS;
            div_cmd.rem_init = {4'b0, elapsed_ff};
            div_cmd.divisor  = {2'b0, motion_ff};
         end
         default: begin
            div_cmd.count = TAU_BITS;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      sf_in        = sf_ff;
      goal_in      = goal_ff;
      start_in     = start_ff;
      delta_in     = delta_ff;
      setpt_in     = setpt_ff;
      out_in       = out_ff;
      out_fin_in   = out_fin_ff;
      rsp_valid_in = rsp_valid_ff;
      fin_in       = fin_ff;
      mul_start_in = 1'b0;
      div_start_in = 1'b0;
      jidx_in      = jidx_ff;
      period_in    = period_ff;
      motion_in    = motion_ff;
      elapsed_in   = elapsed_ff;
      mag_in       = mag_ff;
      tv_in        = tv_ff;
      rsat_in      = rsat_ff;
      tau_in       = tau_ff;
      t2_in        = t2_ff;
      t3_in        = t3_ff;
      s_in         = s_ff;
      prod_in      = prod_ff;

      // register writes; a write restarts planning on the next request
      if (csr_ch.valid) begin
         if (csr_ch.index == CSR_SPEED_FACTOR) begin
            sf_in      = csr_ch.data[SF_W-1:0];
            started_in = 1'b0;
         end else if (csr_ch.index >= CSR_GOAL_FIRST && csr_ch.index <= CSR_GOAL_LAST) begin
            goal_in[csr_goal_idx] = csr_ch.data[ANGLE_W-1:0];
            started_in            = 1'b0;
         end
      end

      // drop the response once taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               period_in = req_ch.period_us;
               if (!started_ff) begin
                  start_in   = req_angle;
                  elapsed_in = '0;
                  motion_in  = '0;
                  jidx_in    = '0;
                  state_in   = ST_DELTA;
               end else begin
                  state_in = ST_ADVANCE;
               end
            end
         end
         ST_DELTA: begin
            delta_in[jidx_ff] = new_delta;
            mag_in            = new_delta[DELTA_W-1] ? ANGLE_W'(-new_delta)
                                                     : new_delta[ANGLE_W-1:0];
            mul_start_in      = 1'b1;
            state_in          = ST_VMUL;
         end
         ST_VMUL: begin
            if (mul_rsp.done) begin
               div_start_in = 1'b1;
               state_in     = ST_VDIV;
            end
         end
         ST_VDIV: begin
            if (div_rsp.done) begin
               tv_in        = (div_rsp.quot[DIV_DQ_W-1:TIME_W] != '0) ? '1
                                                                      : div_rsp.quot[TIME_W-1:0];
               mul_start_in = 1'b1;
               state_in     = ST_KMUL;
            end
         end
         ST_KMUL: begin
            if (mul_rsp.done) begin
               mul_start_in = 1'b1;
               state_in     = ST_AMUL;
            end
         end
         ST_AMUL: begin
            if (mul_rsp.done) begin
               div_start_in = 1'b1;
               state_in     = ST_ADIV;
            end
         end
         ST_ADIV: begin
            if (div_rsp.done) begin
               rsat_in      = (div_rsp.quot[DIV_DQ_W-1:64] != '0) ? '1 : div_rsp.quot[63:0];
               div_start_in = 1'b1;
               state_in     = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (div_rsp.done) begin
               if (bound > motion_ff) begin
                  motion_in = bound;
               end
               if (jidx_ff == JOINT_IDX_W'(JOINT_COUNT - 1)) begin
                  started_in = 1'b1;
                  state_in   = ST_ADVANCE;
               end else begin
                  jidx_in  = jidx_ff + 1'b1;
                  state_in = ST_DELTA;
               end
            end
         end
         ST_ADVANCE: begin
            elapsed_in = elapsed_new;
            fin_in     = (elapsed_new >= motion_ff);
            if (elapsed_new >= motion_ff) begin
               // goal reached, or nothing to move
               setpt_in = goal_ff;
               state_in = ST_FINISH;
            end else begin
               div_start_in = 1'b1;
               state_in     = ST_TAU;
            end
         end
         ST_TAU: begin
            if (div_rsp.done) begin
               tau_in       = div_rsp.quot[FRAC_W-1:0];
               mul_start_in = 1'b1;
               state_in     = ST_T2;
            end
         end
         ST_T2: begin
            if (mul_rsp.done) begin
               t2_in        = mul_rsp.prod[2*FRAC_W-1:FRAC_W];
               mul_start_in = 1'b1;
               state_in     = ST_T3;
            end
         end
         ST_T3: begin
            if (mul_rsp.done) begin
               t3_in        = mul_rsp.prod[2*FRAC_W-1:FRAC_W];
               mul_start_in = 1'b1;
               state_in     = ST_POLY;
            end
         end
         ST_POLY: begin
            if (mul_rsp.done) begin
               s_in         = mul_rsp.prod[FRAC_W +: MUL_B_W];
               jidx_in      = '0;
               mul_start_in = 1'b1;
               state_in     = ST_JMUL;
            end
         end
         ST_JMUL: begin
            if (mul_rsp.done) begin
               prod_in  = mul_rsp.prod[63:0];
               state_in = ST_JSUM;
            end
         end
         ST_JSUM: begin
            setpt_in[jidx_ff] = start_ff[jidx_ff] + scaled;
            if (jidx_ff == JOINT_IDX_W'(JOINT_COUNT - 1)) begin
               state_in = ST_FINISH;
            end else begin
               jidx_in      = jidx_ff + 1'b1;
               mul_start_in = 1'b1;
               state_in     = ST_JMUL;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_in       = setpt_ff;
               out_fin_in   = fin_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff   <= start_in;
      delta_ff   <= delta_in;
      setpt_ff   <= setpt_in;
      out_ff     <= out_in;
      out_fin_ff <= out_fin_in;
      fin_ff     <= fin_in;
      jidx_ff    <= jidx_in;
      period_ff  <= period_in;
      mag_ff     <= mag_in;
      tv_ff      <= tv_in;
      rsat_ff    <= rsat_in;
      tau_ff     <= tau_in;
      t2_ff      <= t2_in;
      t3_ff      <= t3_in;
      s_ff       <= s_in;
      prod_ff    <= prod_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         sf_ff        <= SF_ONE;
         goal_ff      <= '{default: '0};
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         motion_ff    <= '0;
         elapsed_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         sf_ff        <= sf_in;
         goal_ff      <= goal_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         motion_ff    <= motion_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   // Channel outputs
   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.setpoint_0 = out_ff[0];
   assign rsp_ch.setpoint_1 = out_ff[1];
   assign rsp_ch.setpoint_2 = out_ff[2];
   assign rsp_ch.setpoint_3 = out_ff[3];
   assign rsp_ch.setpoint_4 = out_ff[4];
   assign rsp_ch.setpoint_5 = out_ff[5];
   assign rsp_ch.setpoint_6 = out_ff[6];
   assign rsp_ch.finished   = out_fin_ff;

endmodule
